// File: rtl/fractional_step_frame_sampler_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame sampler
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef FRACTIONAL_STEP_FRAME_SAMPLER_MACROS_SVH
`define FRACTIONAL_STEP_FRAME_SAMPLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define FSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fss_pkg.sv
// ---------------------------------------------------------------------------
// fss_pkg
// Shared widths, constants and types of the fractional-step frame sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fss_pkg;

	localparam int MAX_POINTS_DEF = 4096;
	localparam int MAX_FRAME_DEF  = 4096;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int MAX_RES     = 64;
	localparam int RUN_W       = $clog2(MAX_RES + 1);
	localparam int QUEUE_DEPTH = 2;

	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 13;
	localparam int INDEX_W    = 12;
	localparam int TARGET_W   = 13;
	localparam int STEP_W     = 29;
	localparam int STRIDE_W   = 32;
	localparam int POS_W      = 32;
	localparam int FCNT_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [TARGET_W-1:0] TARGET_RST = 13'd4096;
	localparam logic [STEP_W-1:0]   STEP_RST   = 29'd65536;
	localparam logic [STRIDE_W-1:0] STRIDE_RST = 32'd0;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_POINTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_STRIDE  = 2'd2;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_START  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic signed [SAMPLE_W-1:0]  sample;
		logic                        len_zero;
		logic [LEN_W-1:0]            len;
	} cmd_t;

	typedef struct packed {
		logic [TARGET_W-1:0] target_points;
		logic [STEP_W-1:0]   sample_step;
		logic [STRIDE_W-1:0] frame_stride;
	} cfg_t;

endpackage

// File: rtl/fss_if.sv
// ---------------------------------------------------------------------------
// fss_if
// Channel interfaces: sample input, result output, configuration writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fss_in_if import fss_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       first_in_frame;
	logic [LEN_W-1:0]           frame_length;

	modport source (output valid, mode, sample, first_in_frame, frame_length, input ready);
	modport sink (input valid, mode, sample, first_in_frame, frame_length, output ready);
endinterface

interface fss_out_if import fss_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] captured_sample;
	logic [INDEX_W-1:0]         capture_index;
	logic                       last_of_run;
	logic                       capture_full;

	modport source (output valid, captured_sample, capture_index, last_of_run, capture_full,
		input ready);
	modport sink (input valid, captured_sample, capture_index, last_of_run, capture_full,
		output ready);
endinterface

interface fss_cfg_if import fss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/fss_front.sv
// ---------------------------------------------------------------------------
// fss_front
// Input stage: takes beats, classifies them and saturates the frame length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_front import fss_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fss_in_if.sink     samples,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_in;
	logic take;

	assign samples.ready = !valid_s1 || push_ready;
	assign take          = samples.valid && samples.ready;

	always_comb begin
		cmd_in.sample   = samples.sample;
		cmd_in.len_zero = (samples.frame_length == '0);
		if (32'(samples.frame_length) > 32'(MAX_FRAME)) begin
			cmd_in.len = LEN_W'(MAX_FRAME);
		end else begin
			cmd_in.len = samples.frame_length;
		end
		if (samples.mode) begin
			cmd_in.kind = CMD_CLEAR;
		end else if (samples.first_in_frame) begin
			cmd_in.kind = CMD_START;
		end else begin
			cmd_in.kind = CMD_SAMPLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_in;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

// File: rtl/fss_queue.sv
// ---------------------------------------------------------------------------
// fss_queue
// Short command queue between the front stage and the sampling engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_queue import fss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (32'(count_q) < 32'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/fss_back.sv
// ---------------------------------------------------------------------------
// fss_back
// Sampling engine: frame selection, position modulo, pick loop, result reg.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fractional_step_frame_sampler_macros.svh"

module fss_back import fss_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_FRAME  = MAX_FRAME_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	fss_out_if.source  results
);

	localparam int CNT_W    = $clog2(MAX_POINTS + 1);
	localparam int SIF_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int IW       = POS_W - FRAC_BITS;
	localparam int BC_W     = $clog2(IW);
	localparam int ACC_W    = FCNT_W + FRAC_BITS;
	localparam int STEP_MIN = ((1 << FRAC_BITS) + 63) / 64;
	localparam logic [ACC_W:0] ONE_M1 = (ACC_W + 1)'((64'd1 << FRAC_BITS) - 64'd1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FRAME = 4'b0010,
		ST_MOD   = 4'b0100,
		ST_PICK  = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           count_q;
	logic [POS_W-1:0]           pp_q;
	logic [FCNT_W-1:0]          fcnt_q;
	logic [ACC_W-1:0]           acc_q;
	logic [SIF_W-1:0]           sif_q;
	logic                       taken_q;
	logic [LEN_W-1:0]           cur_len_q;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic [LEN_W-1:0]           len_q;
	logic                       len_zero_q;
	logic [LEN_W-1:0]           rem_q;
	logic [IW-1:0]              div_q;
	logic [BC_W-1:0]            bit_cnt_q;
	logic [RUN_W-1:0]           run_n_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic [INDEX_W-1:0]         out_index_q;
	logic                       out_last_q;
	logic                       out_full_q;

	logic [CNT_W-1:0]  eff_target;
	logic [STEP_W-1:0] step_eff;
	logic              stride_ge_one;
	logic [ACC_W:0]    ceil_sum;
	logic [FCNT_W-1:0] ceil_int;
	logic [POS_W:0]    pp_sum;
	logic [POS_W-1:0]  pp_next;
	logic [CNT_W-1:0]  count_inc;
	logic              run_cont;
	logic              cont_next;
	logic              out_free;
	logic              emit;
	logic [CNT_W-1:0]  cnt_fin;
	logic [SIF_W:0]    sif_inc;
	logic              end_frame;
	logic              keep_taken;
	logic [LEN_W:0]    rem_sh;
	logic [LEN_W-1:0]  rem_new;
	logic              pop;

	always_comb begin
		if (32'(cfg.target_points) > 32'(MAX_POINTS)) begin
			eff_target = CNT_W'(MAX_POINTS);
		end else begin
			eff_target = CNT_W'(cfg.target_points);
		end
		if (32'(cfg.sample_step) < 32'(STEP_MIN)) begin
			step_eff = STEP_W'(STEP_MIN);
		end else begin
			step_eff = cfg.sample_step;
		end
		stride_ge_one = |cfg.frame_stride[STRIDE_W-1:FRAC_BITS];
		ceil_sum      = {1'b0, acc_q} + ONE_M1;
		ceil_int      = ceil_sum[FRAC_BITS +: FCNT_W];
		pp_sum        = {1'b0, pp_q} + (POS_W + 1)'(step_eff);
		pp_next       = pp_sum[POS_W] ? '1 : pp_sum[POS_W-1:0];
		count_inc     = count_q + CNT_W'(1);
		run_cont      = (32'(run_n_q) < 32'(MAX_RES)) && (count_q < eff_target)
			&& (32'(pp_q[POS_W-1:FRAC_BITS]) == 32'(sif_q));
		cont_next     = (32'(run_n_q) + 32'd1 < 32'(MAX_RES)) && (count_inc < eff_target)
			&& (32'(pp_next[POS_W-1:FRAC_BITS]) == 32'(sif_q));
		out_free      = !out_valid_q || results.ready;
		emit          = (state_q == ST_PICK) && run_cont && out_free;
		cnt_fin       = run_cont ? count_inc : count_q;
		sif_inc       = {1'b0, sif_q} + (SIF_W + 1)'(1);
		end_frame     = (32'(sif_inc) >= 32'(cur_len_q));
		keep_taken    = !end_frame && (cnt_fin < eff_target);
		rem_sh        = {rem_q, div_q[IW-1]};
		if (rem_sh >= {1'b0, cur_len_q}) begin
			rem_new = LEN_W'(rem_sh - {1'b0, cur_len_q});
		end else begin
			rem_new = LEN_W'(rem_sh);
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			pp_q      <= '0;
			fcnt_q    <= '0;
			acc_q     <= '0;
			sif_q     <= '0;
			taken_q   <= 1'b0;
			cur_len_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (cmd.kind)
							CMD_CLEAR: begin
								count_q <= '0;
								fcnt_q  <= '0;
								acc_q   <= '0;
								sif_q   <= '0;
								taken_q <= 1'b0;
							end
							CMD_START: begin
								state_q <= ST_FRAME;
							end
							CMD_SAMPLE: begin
								if (taken_q) begin
									state_q <= ST_PICK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FRAME: begin
					sif_q   <= '0;
					taken_q <= 1'b0;
					if (len_zero_q || (count_q >= eff_target)) begin
						state_q <= ST_IDLE;
					end else if (stride_ge_one && (ceil_int != fcnt_q)) begin
						fcnt_q  <= fcnt_q + FCNT_W'(1);
						state_q <= ST_IDLE;
					end else begin
						if (stride_ge_one) begin
							fcnt_q <= fcnt_q + FCNT_W'(1);
							acc_q  <= acc_q + ACC_W'(cfg.frame_stride);
						end
						cur_len_q <= len_q;
						state_q   <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (bit_cnt_q == BC_W'(IW - 1)) begin
						pp_q    <= {IW'(rem_new), pp_q[FRAC_BITS-1:0]};
						taken_q <= 1'b1;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (!run_cont || (emit && !cont_next)) begin
						sif_q   <= end_frame ? '0 : SIF_W'(sif_inc);
						taken_q <= keep_taken;
						state_q <= ST_IDLE;
					end
					if (emit) begin
						count_q <= count_inc;
						pp_q    <= pp_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			smp_q      <= cmd.sample;
			len_q      <= cmd.len;
			len_zero_q <= cmd.len_zero;
			run_n_q    <= '0;
		end
		if (state_q == ST_FRAME) begin
			rem_q     <= '0;
			div_q     <= pp_q[POS_W-1:FRAC_BITS];
			bit_cnt_q <= '0;
		end
		if (state_q == ST_MOD) begin
			rem_q     <= rem_new;
			div_q     <= {div_q[IW-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + BC_W'(1);
			run_n_q   <= '0;
		end
		if (emit) begin
			run_n_q <= run_n_q + RUN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sample_q <= smp_q;
			out_index_q  <= INDEX_W'(count_q);
			out_last_q   <= !cont_next;
			out_full_q   <= (count_inc >= eff_target);
		end
	end

	assign results.valid           = out_valid_q;
	assign results.captured_sample = out_sample_q;
	assign results.capture_index   = out_index_q;
	assign results.last_of_run     = out_last_q;
	assign results.capture_full    = out_full_q;

	`FSS_ASSERT_IMPL(a_sif_in_frame, taken_q, 32'(sif_q) < 32'(cur_len_q), "sample index left the frame")
	`FSS_ASSERT_IMPL(a_rem_below_len, state_q == ST_MOD, rem_q < cur_len_q, "remainder not reduced")
	`FSS_ASSERT_IMPL(a_emit_from_pick, $rose(out_valid_q), $past(state_q == ST_PICK), "result outside pick")
	`FSS_ASSERT_IMPL(a_run_cap, state_q == ST_PICK, 32'(run_n_q) < 32'(MAX_RES) || !emit, "run over cap")
	`FSS_ASSERT_NEXT(a_last_ends_run, emit && !cont_next, state_q == ST_IDLE, "run went on after last")

endmodule

// File: rtl/fractional_step_frame_sampler.sv
// ---------------------------------------------------------------------------
// fractional_step_frame_sampler
// Captures target_points samples out of framed 16-bit data, taking frames at
// a fractional stride and samples at a fractional 13.16 step.
// samples: one beat per sample; first_in_frame marks a frame start and then
//   frame_length is read; mode = 1 is a clear of count and frame counters.
// results: one beat per picked sample, last_of_run on the final beat caused
//   by one input beat, capture_full once the count reaches the target.
// cfg: register writes, always ready; index 0 target_points, 1 sample_step,
//   2 frame_stride; write only while the block is idle.
// Path: a sample beat passes the front register, the queue, the idle and pick
//   states of the engine and the result register; a frame start adds the
//   frame state and the position modulo, done one quotient bit per cycle.
// The engine takes a command only while idle, so it finishes the picks of one
//   beat before it takes the next; a clear is done in the idle state.
// A 2-entry queue and the front register buffer input while the result
//   register stalls; a stalled receiver halts the engine, then input once full.
// Reset clears counters, position and frame state; config returns to defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fractional_step_frame_sampler import fss_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_FRAME  = MAX_FRAME_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fss_in_if.sink    samples,
	fss_out_if.source results,
	fss_cfg_if.sink   cfg
);

	logic [TARGET_W-1:0] target_q;
	logic [STEP_W-1:0]   step_q;
	logic [STRIDE_W-1:0] stride_q;
	cfg_t                cfg_regs;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			step_q   <= STEP_RST;
			stride_q <= STRIDE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TARGET_POINTS: target_q <= cfg.data[TARGET_W-1:0];
				REG_SAMPLE_STEP:   step_q   <= cfg.data[STEP_W-1:0];
				REG_FRAME_STRIDE:  stride_q <= cfg.data[STRIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg_regs.target_points = target_q;
		cfg_regs.sample_step   = step_q;
		cfg_regs.frame_stride  = stride_q;
	end

	fss_front #(
		.MAX_FRAME (MAX_FRAME)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	fss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	fss_back #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_FRAME  (MAX_FRAME),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.results   (results)
	);

endmodule

// File: tb/fractional_step_frame_sampler_tb.sv
// ---------------------------------------------------------------------------
// fractional_step_frame_sampler_tb
// Self-checking bench for the frame sampler. A queue-fed driver sends sample,
// frame-start and clear beats with random gaps. A clocked monitor predicts
// every pick from its own copy of the counters, position and registers, and
// compares each result beat field by field while the receiver stalls at random.
// Phases cycle through register settings, extremes included.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fractional_step_frame_sampler_tb;
	import fss_pkg::*;

	localparam int          LIMIT_CYCLES  = 1500000;
	localparam int          SETTLE_CYCLES = 200;
	localparam int          ITEMS_WANTED  = 150;
	localparam logic [63:0] ONE_FX        = 64'd1 << FRAC_BITS_DEF;
	localparam logic [63:0] STEP_FLOOR    = (ONE_FX + 64'd63) / 64'd64;

	typedef enum logic {
		BEAT_SAMPLE = 1'b0,
		BEAT_CLEAR  = 1'b1
	} beat_mode_t;

	typedef struct {
		beat_mode_t                 mode;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       first;
		logic [LEN_W-1:0]           len;
	} sample_beat_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [INDEX_W-1:0]         index;
		logic                       last;
		logic                       full;
	} capture_t;

	logic clk;
	logic arst_n;

	fss_in_if  sample_ch ();
	fss_out_if result_ch ();
	fss_cfg_if cfg_ch ();

	fractional_step_frame_sampler dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	sample_beat_t beats_pending[$];
	capture_t     captures_due[$];
	int           errors        = 0;
	int           beats_queued  = 0;
	int           cycle_count   = 0;
	bit           beat_taken    = 1'b0;
	bit           capture_taken = 1'b0;
	int           in_wait       = 0;
	int           out_wait      = 0;
	bit           in_calm       = 1'b0;
	bit           out_calm      = 1'b0;

	// register copies
	logic [TARGET_W-1:0] reg_target = TARGET_RST;
	logic [STEP_W-1:0]   reg_step   = STEP_RST;
	logic [STRIDE_W-1:0] reg_stride = STRIDE_RST;

	// sampler state
	logic [TARGET_W-1:0] cap_count  = '0;
	logic [POS_W-1:0]    pick_pos   = '0;
	logic [FCNT_W-1:0]   frame_cnt  = '0;
	logic [47:0]         stride_acc = '0;
	logic [LEN_W-1:0]    frame_idx  = '0;
	logic                in_frame   = 1'b0;
	logic [LEN_W-1:0]    frame_len  = '0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void predict_captures(input sample_beat_t b);
		logic [TARGET_W-1:0] tgt;
		logic [63:0]         stp;
		logic [63:0]         nxt;
		logic [63:0]         ceil_sum;
		logic [LEN_W-1:0]    len;
		logic                take;
		capture_t            c;
		capture_t            held;
		int                  n;
		tgt = (reg_target > MAX_POINTS_DEF) ? TARGET_W'(MAX_POINTS_DEF) : reg_target;
		stp = (64'(reg_step) < STEP_FLOOR) ? STEP_FLOOR : 64'(reg_step);
		n = 0;
		if (b.mode == BEAT_CLEAR) begin
			cap_count  = '0;
			frame_cnt  = '0;
			stride_acc = '0;
			frame_idx  = '0;
			in_frame   = 1'b0;
			return;
		end
		if (b.first) begin
			in_frame  = 1'b0;
			frame_idx = '0;
			len       = b.len;
			if (len != 0 && cap_count < tgt) begin
				if (len > MAX_FRAME_DEF)
					len = LEN_W'(MAX_FRAME_DEF);
				take = 1'b1;
				if (64'(reg_stride) >= ONE_FX) begin
					ceil_sum = 64'(stride_acc) + ONE_FX - 64'd1;
					if (ceil_sum[47:16] != frame_cnt)
						take = 1'b0;
					else
						stride_acc = stride_acc + 48'(reg_stride);
					frame_cnt = frame_cnt + 1;
				end
				if (take) begin
					frame_len = len;
					pick_pos  = POS_W'(64'(pick_pos) % (64'(len) << FRAC_BITS_DEF));
					in_frame  = 1'b1;
				end
			end
		end
		if (!in_frame)
			return;
		while (n < MAX_RES && cap_count < tgt && (pick_pos >> FRAC_BITS_DEF) == 32'(frame_idx)) begin
			c.sample  = b.sample;
			c.index   = cap_count[INDEX_W-1:0];
			c.last    = 1'b0;
			cap_count = cap_count + TARGET_W'(1);
			c.full    = (cap_count >= tgt);
			nxt       = 64'(pick_pos) + stp;
			pick_pos  = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
			if (n > 0)
				captures_due = {captures_due, held};
			held = c;
			n++;
		end
		if (n > 0) begin
			held.last = 1'b1;
			captures_due = {captures_due, held};
		end
		frame_idx = frame_idx + LEN_W'(1);
		if (frame_idx >= frame_len || cap_count >= tgt)
			in_frame = 1'b0;
		if (frame_idx >= frame_len)
			frame_idx = '0;
	endfunction

	// sample beats, new data at the falling edge
	always @(negedge clk) begin : beat_driver
		logic         nxt_valid;
		sample_beat_t b;
		if (arst_n) begin
			nxt_valid = sample_ch.valid;
			if (beat_taken) begin
				nxt_valid  = 1'b0;
				beat_taken = 1'b0;
			end
			if (!nxt_valid) begin
				if (in_wait > 0) begin
					in_wait--;
				end else if (beats_pending.size() > 0) begin
					b = beats_pending.pop_front();
					sample_ch.mode           <= b.mode;
					sample_ch.sample         <= b.sample;
					sample_ch.first_in_frame <= b.first;
					sample_ch.frame_length   <= b.len;
					nxt_valid = 1'b1;
					if ($urandom_range(0, 19) == 0)
						in_calm = !in_calm;
					in_wait = in_calm ? 0 : $urandom_range(0, 15);
				end
			end
			sample_ch.valid <= nxt_valid;
		end
	end

	always @(negedge clk) begin : result_pacer
		if (arst_n) begin
			if (capture_taken) begin
				capture_taken = 1'b0;
				if ($urandom_range(0, 19) == 0)
					out_calm = !out_calm;
				out_wait = out_calm ? 0 : $urandom_range(0, 15);
			end
			if (out_wait > 0) begin
				result_ch.ready <= 1'b0;
				out_wait--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		sample_beat_t got;
		capture_t     want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_TARGET_POINTS: reg_target = cfg_ch.data[TARGET_W-1:0];
					REG_SAMPLE_STEP:   reg_step   = cfg_ch.data[STEP_W-1:0];
					REG_FRAME_STRIDE:  reg_stride = cfg_ch.data[STRIDE_W-1:0];
					default: ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready) begin
				got.mode   = beat_mode_t'(sample_ch.mode);
				got.sample = sample_ch.sample;
				got.first  = sample_ch.first_in_frame;
				got.len    = sample_ch.frame_length;
				predict_captures(got);
				beat_taken = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				capture_taken = 1'b1;
				if (captures_due.size() == 0) begin
					errors++;
					$error("result beat with nothing expected: captured_sample %0d capture_index %0d",
						result_ch.captured_sample, result_ch.capture_index);
				end else begin
					want = captures_due.pop_front();
					if (result_ch.captured_sample !== want.sample) begin
						errors++;
						$error("captured_sample: expected %0d, got %0d",
							want.sample, result_ch.captured_sample);
					end
					if (result_ch.capture_index !== want.index) begin
						errors++;
						$error("capture_index: expected %0d, got %0d",
							want.index, result_ch.capture_index);
					end
					if (result_ch.last_of_run !== want.last) begin
						errors++;
						$error("last_of_run: expected %0b, got %0b",
							want.last, result_ch.last_of_run);
					end
					if (result_ch.capture_full !== want.full) begin
						errors++;
						$error("capture_full: expected %0b, got %0b",
							want.full, result_ch.capture_full);
					end
				end
			end
		end
	end

	task automatic push_beat(input beat_mode_t m, input logic [SAMPLE_W-1:0] s,
		input logic f, input logic [LEN_W-1:0] l);
		sample_beat_t b;
		b.mode   = m;
		b.sample = s;
		b.first  = f;
		b.len    = l;
		beats_pending = {beats_pending, b};
		beats_queued++;
	endtask

	task automatic push_random_frame();
		int len;
		int n;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 8);
		n   = (len > 12) ? $urandom_range(1, 6) : len;
		case ($urandom_range(0, 7))
			0: n = n + $urandom_range(1, 2);
			1: if (n > 1) n = $urandom_range(1, n - 1);
			default: ;
		endcase
		push_beat(BEAT_SAMPLE, SAMPLE_W'($urandom_range(0, 65535)), 1'b1, LEN_W'(len));
		for (int i = 1; i < n; i++)
			push_beat(BEAT_SAMPLE, SAMPLE_W'($urandom_range(0, 65535)), 1'b0,
				LEN_W'($urandom_range(1, 4096)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] tgt, input logic [CFG_DATA_W-1:0] stp,
		input logic [CFG_DATA_W-1:0] strd);
		write_reg(REG_TARGET_POINTS, tgt);
		write_reg(REG_SAMPLE_STEP, stp);
		write_reg(REG_FRAME_STRIDE, strd);
	endtask

	// nothing queued, nothing in flight, then room for beats that pick nothing
	task automatic settle();
		do @(posedge clk); while (beats_pending.size() > 0 || sample_ch.valid ||
			captures_due.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int                    phase;
		int                    phase_beats;
		logic [CFG_DATA_W-1:0] tgt;
		logic [CFG_DATA_W-1:0] stp;
		logic [CFG_DATA_W-1:0] strd;
		arst_n                   = 1'b0;
		sample_ch.valid          = 1'b0;
		sample_ch.mode           = 1'b0;
		sample_ch.sample         = '0;
		sample_ch.first_in_frame = 1'b0;
		sample_ch.frame_length   = '0;
		result_ch.ready          = 1'b0;
		cfg_ch.valid             = 1'b0;
		cfg_ch.index             = '0;
		cfg_ch.data              = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		configure(32'd4096, 32'd65536, 32'd0);
		push_beat(BEAT_SAMPLE, 16'h1234, 1'b0, 13'd4);  // no frame taken yet
		push_beat(BEAT_SAMPLE, 16'h8000, 1'b1, 13'd4);
		push_beat(BEAT_SAMPLE, 16'h7FFF, 1'b0, 13'd4);
		push_beat(BEAT_SAMPLE, 16'h0000, 1'b0, 13'd4);
		push_beat(BEAT_SAMPLE, 16'hFFFF, 1'b0, 13'd4);
		push_beat(BEAT_SAMPLE, 16'h0005, 1'b1, 13'd4096);
		push_beat(BEAT_SAMPLE, 16'h0006, 1'b0, 13'd1);
		push_beat(BEAT_SAMPLE, 16'h0008, 1'b1, 13'd0);  // empty frame
		push_beat(BEAT_SAMPLE, 16'h0009, 1'b0, 13'd2);
		push_beat(BEAT_SAMPLE, 16'h000A, 1'b1, 13'd1);
		push_beat(BEAT_SAMPLE, 16'h000B, 1'b0, 13'd1);  // past frame end
		push_beat(BEAT_CLEAR, 16'h000C, 1'b1, 13'd3);
		push_beat(BEAT_SAMPLE, 16'h000D, 1'b1, 13'd2);
		push_beat(BEAT_SAMPLE, 16'h000E, 1'b0, 13'd2);
		settle();

		configure(32'd1, 32'd1024, 32'd0);
		push_beat(BEAT_SAMPLE, 16'h0101, 1'b1, 13'd2);
		push_beat(BEAT_SAMPLE, 16'h0102, 1'b0, 13'd2);
		push_beat(BEAT_SAMPLE, 16'h0103, 1'b1, 13'd2);  // already full
		push_beat(BEAT_CLEAR, 16'h0000, 1'b0, 13'd1);
		push_beat(BEAT_SAMPLE, 16'h0104, 1'b1, 13'd1);
		settle();

		configure(32'd4096, 32'd268435456, 32'd163840);
		for (int i = 0; i < 5; i++)
			push_beat(BEAT_SAMPLE, SAMPLE_W'($urandom_range(0, 65535)), 1'b1, 13'd3);
		settle();

		phase = 0;
		while (beats_queued < ITEMS_WANTED && phase < 20) begin
			case ($urandom_range(0, 3))
				0: tgt = 32'd1;
				1: tgt = 32'd4096;
				2: tgt = $urandom_range(1, 64);
				default: tgt = $urandom_range(1, 4096);
			endcase
			case ($urandom_range(0, 4))
				0: stp = 32'd1024;
				1: stp = 32'd268435456;
				2: stp = $urandom_range(1024, 65536);
				3: stp = $urandom_range(65536, 262144);
				default: stp = $urandom_range(1024, 268435456);
			endcase
			case ($urandom_range(0, 5))
				0: strd = 32'd0;
				1: strd = $urandom_range(0, 65535);
				2: strd = 32'd65536;
				3: strd = $urandom_range(65536, 262144);
				4: strd = 32'hFFFF_FFFF;
				default: strd = $urandom();
			endcase
			configure(tgt, stp, strd);
			phase_beats = beats_queued;
			while (beats_queued - phase_beats < 25) begin
				case ($urandom_range(0, 19))
					0: push_beat(BEAT_CLEAR, SAMPLE_W'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)), LEN_W'($urandom_range(1, 4096)));
					1: push_beat(BEAT_SAMPLE, SAMPLE_W'($urandom_range(0, 65535)), 1'b0,
						LEN_W'($urandom_range(1, 4096)));
					default: push_random_frame();
				endcase
			end
			settle();
			phase++;
		end

		if (errors == 0)
			$display("fractional_step_frame_sampler_tb: done, clean");
		else
			$display("fractional_step_frame_sampler_tb: done, errors");
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("fractional_step_frame_sampler_tb: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fss_pkg.sv
rtl/fss_if.sv
rtl/fss_front.sv
rtl/fss_queue.sv
rtl/fss_back.sv
rtl/fractional_step_frame_sampler.sv
tb/fractional_step_frame_sampler_tb.sv
